/* hdl/irpa_pkg.sv */
package irpa_pkg;

    localparam int INDEX_W   = 10;
    localparam int LANES     = 32;
    localparam int LANE_W    = 5;
    localparam int GROUP     = 4;
    localparam int NGROUPS   = LANES / GROUP;
    localparam int ENTRY_W   = 14;
    localparam int ROW_W     = ENTRY_W * LANES;
    localparam int MAX_INDEX = 1 << INDEX_W;

    localparam logic [2:0] MAX_CPU = 3'd5;
    localparam logic [2:0] TGT_DMA = 3'd1;

    // write word bit positions
    localparam int WB_EN     = 10;
    localparam int WB_TGT    = 11;
    localparam int WB_REQ    = 24;
    localparam int WB_CLR    = 25;
    localparam int WB_SET    = 26;
    localparam int WB_OVF    = 27;
    localparam int WB_OVFCLR = 28;

    typedef enum logic [2:0] {
        ACT_READ      = 3'd0,
        ACT_WRITE     = 3'd1,
        ACT_ASSERT    = 3'd2,
        ACT_CLEAR     = 3'd3,
        ACT_ACK       = 3'd4,
        ACT_CONFIG    = 3'd5,
        ACT_QUERY_CPU = 3'd6,
        ACT_QUERY_DMA = 3'd7
    } t_action;

    typedef struct packed {
        logic       ovf;
        logic       req;
        logic [2:0] tgt;
        logic       en;
        logic [7:0] prio;
    } t_entry;

    typedef t_entry [LANES-1:0] t_row;

    typedef struct packed {
        t_action      action;
        logic [9:0]   entry_index;
        logic [31:0]  write_value;
        logic [7:0]   new_priority;
        logic [2:0]   new_target;
        logic         new_enable;
        logic [2:0]   query_cpu;
        logic [7:0]   current_priority;
        logic         interrupts_enabled;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        found;
        logic [9:0]  winner_index;
        logic [7:0]  winner_priority;
        logic        take_interrupt;
    } t_out_item;

    typedef struct packed {
        logic cnt_clr;
        logic cnt_inc;
        logic clear_wr;
        logic capture;
        logic best_clr;
        logic entry_rd;
        logic entry_commit;
        logic scan_rd;
        logic scan_commit;
    } t_cmd;

    typedef struct packed {
        logic cnt_last;
        logic pipe_busy;
        logic out_free;
        logic is_query;
        logic skip_scan;
    } t_stat;

endpackage

/* hdl/irpa_ram.sv */
module irpa_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 16
    )
    (
        input  logic                                i_clk,
        input  logic                                i_wr_en,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
        input  logic [WIDTH-1:0]                    i_wr_data,
        input  logic                                i_rd_en,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
        output logic [WIDTH-1:0]                    o_rd_data
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, hold between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/irpa_ctrl.sv */
module irpa_ctrl
    import irpa_pkg::*;
    (
        input  logic  i_clk,
        input  logic  i_rst_n,
        input  logic  i_in_valid,
        output logic  o_in_ready,
        input  t_stat i_stat,
        output t_cmd  o_cmd
    );

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_MODIFY = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // sequence one transaction at a time
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_stat.cnt_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture  = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    o_cmd.best_clr = 1'b1;
                    n_state        = ST_READ;
                end
            end
            ST_READ: begin
                if (!i_stat.is_query) begin
                    o_cmd.entry_rd = 1'b1;
                    n_state        = ST_MODIFY;
                end else if (i_stat.skip_scan) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_MODIFY: begin
                if (i_stat.out_free) begin
                    o_cmd.entry_commit = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.scan_commit = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/irpa_dpath.sv */
module irpa_dpath
    import irpa_pkg::*;
    #(
        parameter int NUM_SOURCES = 1024
    )
    (
        input  logic      i_clk,
        input  logic      i_rst_n,
        input  t_in_item  i_in_data,
        input  logic      i_out_ready,
        output logic      o_out_valid,
        output t_out_item o_out_data,
        input  t_cmd      i_cmd,
        output t_stat     o_stat
    );

    localparam int EFF    = (NUM_SOURCES < MAX_INDEX) ? NUM_SOURCES : MAX_INDEX;
    localparam int ROWS   = (EFF + LANES - 1) / LANES;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    t_in_item            r_item;
    logic [ROW_AW-1:0]   r_cnt;
    logic                r_v1;
    logic [ROW_AW-1:0]   r_row1;
    logic                r_v2;
    logic [ROW_AW-1:0]   r_row2;
    logic [7:0]          r_grp_prio [NGROUPS];
    logic [LANE_W-1:0]   r_grp_lane [NGROUPS];
    logic [7:0]          r_best_prio;
    logic [INDEX_W-1:0]  r_best_idx;
    logic                r_out_valid;
    t_out_item           r_out_data;

    logic [7:0]          n_grp_prio [NGROUPS];
    logic [LANE_W-1:0]   n_grp_lane [NGROUPS];
    logic [7:0]          n_best_prio;
    logic [INDEX_W-1:0]  n_best_idx;

    logic [ROW_AW-1:0]   item_row;
    logic [LANE_W-1:0]   item_lane;
    logic                idx_valid;
    logic [2:0]          code;
    logic [ROW_W-1:0]    rd_data;
    t_row                rd_row;
    t_row                mod_row;
    t_entry              cur_e;
    t_entry              new_e;
    logic                does_write;
    logic [31:0]         word;
    logic                ram_wr_en;
    logic [ROW_AW-1:0]   ram_wr_addr;
    logic [ROW_W-1:0]    ram_wr_data;
    logic                ram_rd_en;
    logic [ROW_AW-1:0]   ram_rd_addr;
    t_out_item           entry_res;
    t_out_item           query_res;

    // decode addressed entry
    assign item_row  = ROW_AW'(r_item.entry_index >> LANE_W);
    assign item_lane = r_item.entry_index[LANE_W-1:0];
    assign idx_valid = 32'(r_item.entry_index) < 32'(NUM_SOURCES);
    assign code      = (r_item.action == ACT_QUERY_DMA) ? TGT_DMA :
                       (r_item.query_cpu == 3'd0) ? 3'd0 : r_item.query_cpu + 3'd1;

    // capture transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
    end

    // row counter for clearing pass and scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + ROW_AW'(1);
        end
    end

    // table memory, one row of entries per word
    assign ram_rd_en   = i_cmd.entry_rd | i_cmd.scan_rd;
    assign ram_rd_addr = i_cmd.scan_rd ? r_cnt : item_row;
    assign ram_wr_en   = i_cmd.clear_wr | (i_cmd.entry_commit & does_write & idx_valid);
    assign ram_wr_addr = i_cmd.clear_wr ? r_cnt : item_row;
    assign ram_wr_data = i_cmd.clear_wr ? '0 : ROW_W'(mod_row);

    irpa_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_row = t_row'(rd_data);

    // modify one entry of the read row
    always_comb begin
        cur_e      = rd_row[item_lane];
        new_e      = cur_e;
        does_write = 1'b1;
        case (r_item.action)
            ACT_WRITE: begin
                new_e.prio = r_item.write_value[7:0];
                new_e.en   = r_item.write_value[WB_EN];
                new_e.tgt  = r_item.write_value[WB_TGT +: 3];
                if (r_item.write_value[WB_CLR]) begin
                    new_e.req = 1'b0;
                end
                if (r_item.write_value[WB_SET]) begin
                    if (new_e.req) begin
                        new_e.ovf = 1'b1;
                    end
                    new_e.req = 1'b1;
                end
                if (r_item.write_value[WB_OVFCLR]) begin
                    new_e.ovf = 1'b0;
                end
            end
            ACT_ASSERT: begin
                if (cur_e.req) begin
                    new_e.ovf = 1'b1;
                end
                new_e.req = 1'b1;
            end
            ACT_CLEAR, ACT_ACK: begin
                new_e.req = 1'b0;
            end
            ACT_CONFIG: begin
                new_e.prio = r_item.new_priority;
                new_e.tgt  = r_item.new_target;
                new_e.en   = r_item.new_enable;
            end
            default: begin
                does_write = 1'b0;
            end
        endcase
        mod_row            = rd_row;
        mod_row[item_lane] = new_e;
    end

    // entry word for a read
    always_comb begin
        word             = '0;
        word[7:0]        = cur_e.prio;
        word[WB_EN]      = cur_e.en;
        word[WB_TGT +: 3] = cur_e.tgt;
        word[WB_REQ]     = cur_e.req;
        word[WB_OVF]     = cur_e.ovf;
        entry_res        = '0;
        if (r_item.action == ACT_READ && idx_valid) begin
            entry_res.read_data = word;
        end
    end

    // first scan stage: best of each lane group
    always_comb begin
        t_entry            e;
        logic [7:0]        p;
        for (int g = 0; g < NGROUPS; g++) begin
            n_grp_prio[g] = '0;
            n_grp_lane[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                e = rd_row[g*GROUP + k];
                p = (e.req && e.en && e.tgt == code) ? e.prio : 8'd0;
                if (p > n_grp_prio[g]) begin
                    n_grp_prio[g] = p;
                    n_grp_lane[g] = LANE_W'(g*GROUP + k);
                end
            end
        end
    end

    // second scan stage: merge groups into the running best
    always_comb begin
        n_best_prio = r_best_prio;
        n_best_idx  = r_best_idx;
        for (int g = 0; g < NGROUPS; g++) begin
            if (r_grp_prio[g] > n_best_prio) begin
                n_best_prio = r_grp_prio[g];
                n_best_idx  = (INDEX_W'(r_row2) << LANE_W) | INDEX_W'(r_grp_lane[g]);
            end
        end
    end

    // scan pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_rd;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row1 <= r_cnt;
        r_row2 <= r_row1;
        for (int g = 0; g < NGROUPS; g++) begin
            r_grp_prio[g] <= n_grp_prio[g];
            r_grp_lane[g] <= n_grp_lane[g];
        end
    end

    // running best
    always_ff @(posedge i_clk) begin
        if (i_cmd.best_clr) begin
            r_best_prio <= '0;
            r_best_idx  <= '0;
        end else if (r_v2) begin
            r_best_prio <= n_best_prio;
            r_best_idx  <= n_best_idx;
        end
    end

    // query result
    always_comb begin
        query_res                 = '0;
        query_res.found           = r_best_prio != 8'd0;
        query_res.winner_index    = r_best_idx;
        query_res.winner_priority = r_best_prio;
        query_res.take_interrupt  = (r_item.action == ACT_QUERY_CPU) &&
                                    r_item.interrupts_enabled && query_res.found &&
                                    (r_best_prio > r_item.current_priority);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.entry_commit || i_cmd.scan_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.entry_commit) begin
            r_out_data <= entry_res;
        end else if (i_cmd.scan_commit) begin
            r_out_data <= query_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // status to controller
    assign o_stat.cnt_last  = r_cnt == ROW_AW'(ROWS - 1);
    assign o_stat.pipe_busy = r_v1 | r_v2;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.is_query  = (r_item.action == ACT_QUERY_CPU) ||
                              (r_item.action == ACT_QUERY_DMA);
    assign o_stat.skip_scan = (r_item.action == ACT_QUERY_CPU) &&
                              (r_item.query_cpu > MAX_CPU);

endmodule

/* hdl/interrupt_router_priority_arbiter_core.sv */
// Entry actions (read, write, assert, clear, acknowledge, configure) read the
// addressed row, and all but a read write back the modified entry. Queries scan
// one row of 32 entries per cycle; a CPU query above the last CPU skips the scan.
// One transaction in flight; the next is accepted while a result waits.
// Reset (synchronous, active low) starts a clearing pass over every row, during
// which no transaction is accepted.
module interrupt_router_priority_arbiter_core
    import irpa_pkg::*;
    #(
        parameter int NUM_SOURCES = 1024
    )
    (
        input  logic      i_clk,
        input  logic      i_rst_n,
        input  logic      i_in_valid,
        output logic      o_in_ready,
        input  t_in_item  i_in_data,
        output logic      o_out_valid,
        input  logic      i_out_ready,
        output t_out_item o_out_data
    );

    t_cmd  cmd;
    t_stat stat;

    irpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    irpa_dpath #(.NUM_SOURCES(NUM_SOURCES)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

/* hdl/irpa_checker.sv */
module irpa_checker
    import irpa_pkg::*;
    (
        input logic      i_clk,
        input logic      i_rst_n,
        input logic      i_in_valid,
        input logic      o_in_ready,
        input t_in_item  i_in_data,
        input logic      o_out_valid,
        input logic      i_out_ready,
        input t_out_item o_out_data
    );

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // no winner means empty winner fields
    a_no_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            o_out_data.winner_index == 10'd0 && o_out_data.winner_priority == 8'd0 &&
            !o_out_data.take_interrupt)
        else $error("winner fields set without a winner");

    // a winner has nonzero priority and carries no read word
    a_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |->
            o_out_data.winner_priority != 8'd0 && o_out_data.read_data == 32'd0)
        else $error("bad winner result");

    // nothing is accepted right after reset, during the clearing pass
    a_clear_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("transaction during clearing pass");

endmodule

bind interrupt_router_priority_arbiter_core irpa_checker u_chk (.*);

/* tb/sv/irpa_checker.sv */
module irpa_tb_checker
    import irpa_pkg::*;
    (
        input  logic      i_clk,
        input  logic      i_rst_n,
        input  logic      i_in_valid,
        input  logic      i_in_ready,
        input  t_in_item  i_in_data,
        input  logic      i_out_valid,
        input  logic      i_out_ready,
        input  t_out_item i_out_data,
        output int        o_fail_count,
        output int        o_pending
    );
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSRC = 1024;

    t_entry    table_m [NSRC];
    t_out_item expected_q [$];

    // Build the bus word for one entry.
    function automatic logic [31:0] entry_to_word(t_entry e);
        logic [31:0] w;
        w = '0;
        w[7:0] = e.prio;
        w[WB_EN] = e.en;
        w[WB_TGT +: 3] = e.tgt;
        w[WB_REQ] = e.req;
        w[WB_OVF] = e.ovf;
        return w;
    endfunction

    // Scan for highest enabled pending entry with given target code.
    function automatic t_out_item scan_table(logic [2:0] code);
        t_out_item r;
        r = '0;
        for (int i = 0; i < NSRC; i++) begin
            if (table_m[i].req && table_m[i].en && table_m[i].tgt == code &&
                table_m[i].prio > r.winner_priority) begin
                r.found = 1'b1;
                r.winner_index = i[9:0];
                r.winner_priority = table_m[i].prio;
            end
        end
        return r;
    endfunction

    // Apply one transaction to the table and return its result.
    function automatic t_out_item apply_action(t_in_item t);
        t_out_item r;
        t_entry e;
        logic [31:0] wv;
        r = '0;
        e = table_m[t.entry_index];
        wv = t.write_value;
        case (t.action)
            ACT_READ: r.read_data = entry_to_word(e);
            ACT_WRITE: begin
                e.prio = wv[7:0];
                e.en = wv[WB_EN];
                e.tgt = wv[WB_TGT +: 3];
                if (wv[WB_CLR]) e.req = 1'b0;
                if (wv[WB_SET]) begin
                    if (e.req) e.ovf = 1'b1;
                    e.req = 1'b1;
                end
                if (wv[WB_OVFCLR]) e.ovf = 1'b0;
                table_m[t.entry_index] = e;
            end
            ACT_ASSERT: begin
                if (e.req) e.ovf = 1'b1;
                e.req = 1'b1;
                table_m[t.entry_index] = e;
            end
            ACT_CLEAR, ACT_ACK: begin
                e.req = 1'b0;
                table_m[t.entry_index] = e;
            end
            ACT_CONFIG: begin
                e.prio = t.new_priority;
                e.tgt = t.new_target;
                e.en = t.new_enable;
                table_m[t.entry_index] = e;
            end
            ACT_QUERY_CPU: begin
                if (t.query_cpu <= MAX_CPU) begin
                    r = scan_table(t.query_cpu == 3'd0 ? 3'd0 : t.query_cpu + 3'd1);
                    r.take_interrupt = t.interrupts_enabled && r.found &&
                                       r.winner_priority > t.current_priority;
                end
            end
            default: r = scan_table(TGT_DMA);
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item x;
        if (!i_rst_n) begin
            foreach (table_m[i]) table_m[i] = '0;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            // Compare result transaction with oldest expectation.
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    x = expected_q.pop_front();
                    if (i_out_data != x) begin
                        o_fail_count <= o_fail_count + 1;
                        if (i_out_data.read_data != x.read_data)
                            $error("read_data exp %h got %h", x.read_data,
                                   i_out_data.read_data);
                        if (i_out_data.found != x.found)
                            $error("found exp %0d got %0d", x.found, i_out_data.found);
                        if (i_out_data.winner_index != x.winner_index)
                            $error("winner_index exp %0d got %0d", x.winner_index,
                                   i_out_data.winner_index);
                        if (i_out_data.winner_priority != x.winner_priority)
                            $error("winner_priority exp %0d got %0d",
                                   x.winner_priority, i_out_data.winner_priority);
                        if (i_out_data.take_interrupt != x.take_interrupt)
                            $error("take_interrupt exp %0d got %0d",
                                   x.take_interrupt, i_out_data.take_interrupt);
                    end
                end
            end
            // Predict on each accepted input transaction.
            if (i_in_valid && i_in_ready) expected_q.push_back(apply_action(i_in_data));
        end
        o_pending <= expected_q.size();
    end

endmodule

/* tb/sv/tb.sv */
module tb;
    import irpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    int        burst_left;
    int        stall_mode;

    interrupt_router_priority_arbiter_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    irpa_tb_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver stall pattern: phases of always-ready, random, and heavy stall.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Random item, biased toward a small window of entries to build contention.
    function automatic t_in_item rand_item();
        t_in_item t;
        t.action = t_action'($urandom_range(0, 7));
        t.entry_index = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                   : 10'($urandom_range(0, 15));
        t.write_value = $urandom;
        if ($urandom_range(0, 1)) t.write_value[WB_TGT +: 3] = 3'($urandom_range(0, 2));
        t.new_priority = 8'($urandom);
        t.new_target = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
        t.new_enable = ($urandom_range(0, 3) != 0);
        t.query_cpu = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1));
        t.current_priority = 8'($urandom);
        t.interrupts_enabled = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // Present one transaction with optional leading gap and hold until accepted.
    task automatic send_item(t_in_item t);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= t;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_op(t_action a, int idx, logic [31:0] wv, logic [7:0] p,
                           logic [2:0] tg, logic en, logic [2:0] cpu,
                           logic [7:0] cur, logic ie);
        t_in_item t;
        t = '{a, idx[9:0], wv, p, tg, en, cpu, cur, ie};
        send_item(t);
    endtask

    initial begin
        t_in_item t;
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        burst_left = 5;
        stall_mode = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: configure, tie, zero priority, overflow, extremes.
        send_op(ACT_CONFIG, 0, 0, 8'd0, 3'd0, 1'b1, 0, 0, 0);
        send_op(ACT_ASSERT, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_QUERY_CPU, 0, 0, 0, 0, 0, 3'd0, 8'd0, 1'b1);
        send_op(ACT_CONFIG, 5, 0, 8'd200, 3'd0, 1'b1, 0, 0, 0);
        send_op(ACT_CONFIG, 1023, 0, 8'd200, 3'd0, 1'b1, 0, 0, 0);
        send_op(ACT_ASSERT, 1023, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_ASSERT, 5, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_ASSERT, 5, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_READ, 5, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_QUERY_CPU, 0, 0, 0, 0, 0, 3'd0, 8'd199, 1'b1);
        send_op(ACT_QUERY_CPU, 0, 0, 0, 0, 0, 3'd0, 8'd200, 1'b1);
        send_op(ACT_QUERY_CPU, 0, 0, 0, 0, 0, 3'd7, 8'd0, 1'b1);
        send_op(ACT_WRITE, 7, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        send_op(ACT_READ, 7, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_WRITE, 7, 32'h0400_0CFF, 0, 0, 0, 0, 0, 0);
        send_op(ACT_READ, 7, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_QUERY_DMA, 0, 0, 0, 0, 0, 3'd0, 8'd0, 1'b1);
        send_op(ACT_QUERY_CPU, 0, 0, 0, 0, 0, 3'd6, 8'd0, 1'b1);
        send_op(ACT_CLEAR, 5, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_ACK, 1023, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_WRITE, 5, 32'h1000_0000, 0, 0, 0, 0, 0, 0);
        send_op(ACT_READ, 5, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_READ, 1023, 0, 0, 0, 0, 0, 0, 0);

        // Hold off until every expected result has drained.
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        for (int n = 0; n < 450; n++) begin
            t = rand_item();
            send_item(t);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
hdl/irpa_pkg.sv
hdl/irpa_ram.sv
hdl/irpa_ctrl.sv
hdl/irpa_dpath.sv
hdl/interrupt_router_priority_arbiter_core.sv
hdl/irpa_checker.sv
tb/sv/irpa_checker.sv
tb/sv/tb.sv
